@@ design/fcsi_pkg.sv @@
// ---------------------------------------------------------------------------
// Feistel cache set index package
// Shared sizes, command and state codes, register indexes and the structs
// that connect the table store with the control and round logic.
// ---------------------------------------------------------------------------
`default_nettype none

package fcsi_pkg;

    localparam int NUM_ROUNDS = 4;
    localparam int HALF_BITS  = 16;

    localparam int LINE_W    = 2 * HALF_BITS;
    localparam int ROUND_W   = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam int ADDR_W    = 48;
    localparam int DATA_W    = 32;
    localparam int DEST_W    = 4;
    localparam int ROW_W     = 4;
    localparam int STAGE_W   = 2;
    localparam int CMD_W     = 2;
    localparam int OFFSET_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [OFFSET_W-1:0] OFFSET_BITS_RESET = OFFSET_W'(6);
    localparam logic [DATA_W-1:0]   SET_MASK_RESET    = DATA_W'(1023);

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SET_MASK    = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_COMPUTE = 2'd0,
        CMD_KEY     = 2'd1,
        CMD_SUBST   = 2'd2,
        CMD_PERM    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               en;
        t_cmd               cmd;
        logic [ROUND_W-1:0] stage;
        logic [ROW_W-1:0]   row;
        logic [DATA_W-1:0]  data;
    } t_tbl_wr;

    typedef struct packed {
        logic [HALF_BITS-1:0]                key;
        logic [HALF_BITS-1:0][DATA_W-1:0]    masks;
        logic [HALF_BITS-1:0][DEST_W-1:0]    targets;
    } t_tbl_rd;

endpackage

`default_nettype wire

@@ design/fcsi_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module fcsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/fcsi_tables.sv @@
// ---------------------------------------------------------------------------
// Feistel cache set index tables
// Stage keys, substitution masks and permutation targets: one key RAM and
// one mask and one target lane per row, all read at the same round address.
// ---------------------------------------------------------------------------
`default_nettype none

module fcsi_tables (
    input  wire logic                         i_clk,
    input  wire fcsi_pkg::t_tbl_wr            i_wr,
    input  wire logic [fcsi_pkg::ROUND_W-1:0] i_raddr,
    output fcsi_pkg::t_tbl_rd                 o_rd
);

    logic key_we;

    assign key_we = i_wr.en && (i_wr.cmd == fcsi_pkg::CMD_KEY);

    fcsi_ram #(
        .WIDTH(fcsi_pkg::HALF_BITS),
        .DEPTH(fcsi_pkg::NUM_ROUNDS)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(i_wr.stage),
        .i_wdata(i_wr.data[fcsi_pkg::HALF_BITS-1:0]),
        .i_raddr(i_raddr),
        .o_rdata(o_rd.key)
    );

    for (genvar r = 0; r < fcsi_pkg::HALF_BITS; r++) begin : g_row
        logic row_hit;
        logic mask_we;
        logic target_we;

        assign row_hit   = i_wr.en && (i_wr.row == fcsi_pkg::ROW_W'(r));
        assign mask_we   = row_hit && (i_wr.cmd == fcsi_pkg::CMD_SUBST);
        assign target_we = row_hit && (i_wr.cmd == fcsi_pkg::CMD_PERM);

        fcsi_ram #(
            .WIDTH(fcsi_pkg::DATA_W),
            .DEPTH(fcsi_pkg::NUM_ROUNDS)
        ) u_mask_ram (
            .i_clk  (i_clk),
            .i_we   (mask_we),
            .i_waddr(i_wr.stage),
            .i_wdata(i_wr.data),
            .i_raddr(i_raddr),
            .o_rdata(o_rd.masks[r])
        );

        fcsi_ram #(
            .WIDTH(fcsi_pkg::DEST_W),
            .DEPTH(fcsi_pkg::NUM_ROUNDS)
        ) u_target_ram (
            .i_clk  (i_clk),
            .i_we   (target_we),
            .i_waddr(i_wr.stage),
            .i_wdata(i_wr.data[fcsi_pkg::DEST_W-1:0]),
            .i_raddr(i_raddr),
            .o_rdata(o_rd.targets[r])
        );
    end

endmodule

`default_nettype wire

@@ design/fcsi_round_unit.sv @@
// ---------------------------------------------------------------------------
// Feistel cache set index round unit
// One Feistel round: keyed parity substitution, bit permutation and the
// XOR into the right half.
// ---------------------------------------------------------------------------
`default_nettype none

module fcsi_round_unit (
    input  wire logic [fcsi_pkg::HALF_BITS-1:0] i_left,
    input  wire logic [fcsi_pkg::HALF_BITS-1:0] i_right,
    input  wire fcsi_pkg::t_tbl_rd              i_tbl,
    output logic      [fcsi_pkg::HALF_BITS-1:0] o_next
);

    logic [fcsi_pkg::DATA_W-1:0]    joined;
    logic [fcsi_pkg::HALF_BITS-1:0] sub;
    logic [fcsi_pkg::HALF_BITS-1:0] perm;

    assign joined = fcsi_pkg::DATA_W'({i_left, i_tbl.key});

    always_comb begin
        for (int r = 0; r < fcsi_pkg::HALF_BITS; r++) begin
            sub[fcsi_pkg::HALF_BITS-1-r] = ^(joined & i_tbl.masks[r]);
        end
    end

    always_comb begin
        perm = '0;
        for (int k = 0; k < fcsi_pkg::HALF_BITS; k++) begin
            for (int r = 0; r < fcsi_pkg::HALF_BITS; r++) begin
                if (sub[r] && (i_tbl.targets[r] == fcsi_pkg::DEST_W'(k))) begin
                    perm[k] = 1'b1;
                end
            end
        end
    end

    assign o_next = perm ^ i_right;

endmodule

`default_nettype wire

@@ design/feistel_cache_set_index.sv @@
// ---------------------------------------------------------------------------
// Feistel cache set index
// Top level: command decode, round sequencer, configuration registers and
// result register.
// ---------------------------------------------------------------------------
// A table write (key, substitution mask or permutation entry) is accepted
// while the block is idle and returns no result. A compute transfer is
// accepted only while the block is idle and runs each Feistel round in turn
// through the single shared round unit, whose table lanes are read one round
// ahead, then loads the result into the output register once the output side
// is free. A new item is accepted only after that result is loaded and the
// block is back in idle. The tables are not cleared after reset; every entry
// a computation uses must be written first.
`default_nettype none

module feistel_cache_set_index (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [fcsi_pkg::CMD_W-1:0]     i_command,
    input  wire logic [fcsi_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [fcsi_pkg::STAGE_W-1:0]   i_stage_select,
    input  wire logic [fcsi_pkg::ROW_W-1:0]     i_row_select,
    input  wire logic [fcsi_pkg::DATA_W-1:0]    i_write_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [fcsi_pkg::DATA_W-1:0]    o_set_index,
    output logic      [fcsi_pkg::DATA_W-1:0]    o_encrypted_line,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcsi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fcsi_pkg::DATA_W-1:0]    i_cfg_data
);

    fcsi_pkg::t_state                 r_state;
    fcsi_pkg::t_state                 n_state;
    logic [fcsi_pkg::ROUND_W-1:0]     r_round;
    logic [fcsi_pkg::ROUND_W-1:0]     n_round;
    logic [fcsi_pkg::HALF_BITS-1:0]   r_left;
    logic [fcsi_pkg::HALF_BITS-1:0]   r_right;
    logic [fcsi_pkg::OFFSET_W-1:0]    r_offset_bits;
    logic [fcsi_pkg::DATA_W-1:0]      r_set_mask;
    logic                             r_out_valid;
    logic [fcsi_pkg::DATA_W-1:0]      r_set_index;
    logic [fcsi_pkg::DATA_W-1:0]      r_encrypted;

    logic                             in_accept;
    logic                             start;
    logic                             round_en;
    logic                             load_out;
    logic                             last_round;
    logic [fcsi_pkg::ADDR_W-1:0]      shifted;
    logic [fcsi_pkg::LINE_W-1:0]      line;
    logic [fcsi_pkg::HALF_BITS-1:0]   round_next;
    logic [fcsi_pkg::DATA_W-1:0]      enc;
    fcsi_pkg::t_tbl_wr                tbl_wr;
    fcsi_pkg::t_tbl_rd                tbl_rd;

    assign in_accept  = i_in_valid && o_in_ready;
    assign start      = in_accept && (i_command == fcsi_pkg::CMD_COMPUTE);
    assign last_round = (r_round == fcsi_pkg::ROUND_W'(fcsi_pkg::NUM_ROUNDS - 1));

    assign tbl_wr.en    = in_accept && (i_command != fcsi_pkg::CMD_COMPUTE)
                          && (int'(i_stage_select) < fcsi_pkg::NUM_ROUNDS);
    assign tbl_wr.cmd   = fcsi_pkg::t_cmd'(i_command);
    assign tbl_wr.stage = fcsi_pkg::ROUND_W'(i_stage_select);
    assign tbl_wr.row   = i_row_select;
    assign tbl_wr.data  = i_write_data;

    fcsi_tables u_tables (
        .i_clk  (i_clk),
        .i_wr   (tbl_wr),
        .i_raddr(n_round),
        .o_rd   (tbl_rd)
    );

    fcsi_round_unit u_round (
        .i_left (r_left),
        .i_right(r_right),
        .i_tbl  (tbl_rd),
        .o_next (round_next)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            fcsi_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = fcsi_pkg::ST_ROUND;
                end
            end
            fcsi_pkg::ST_ROUND: begin
                if (last_round) begin
                    n_state = fcsi_pkg::ST_DONE;
                end
            end
            fcsi_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = fcsi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fcsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        round_en   = 1'b0;
        load_out   = 1'b0;
        n_round    = '0;
        case (r_state)
            fcsi_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            fcsi_pkg::ST_ROUND: begin
                round_en = 1'b1;
                n_round  = r_round + 1'b1;
            end
            fcsi_pkg::ST_DONE: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign shifted = i_address >> r_offset_bits;
    assign line    = shifted[fcsi_pkg::LINE_W-1:0];
    assign enc     = fcsi_pkg::DATA_W'({r_left, r_right});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcsi_pkg::ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_left  <= line[fcsi_pkg::LINE_W-1:fcsi_pkg::HALF_BITS];
            r_right <= line[fcsi_pkg::HALF_BITS-1:0];
        end else if (round_en) begin
            r_left  <= r_right;
            r_right <= round_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= fcsi_pkg::OFFSET_BITS_RESET;
            r_set_mask    <= fcsi_pkg::SET_MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fcsi_pkg::REG_OFFSET_BITS: r_offset_bits <= i_cfg_data[fcsi_pkg::OFFSET_W-1:0];
                fcsi_pkg::REG_SET_MASK:    r_set_mask    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_set_index <= enc & r_set_mask;
            r_encrypted <= enc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_set_index      = r_set_index;
    assign o_encrypted_line = r_encrypted;

endmodule

`default_nettype wire

@@ design/fcsi_checker.sv @@
// ---------------------------------------------------------------------------
// Feistel cache set index checker
// Port-level assertions on the top level, attached with a bind statement.
// ---------------------------------------------------------------------------
`default_nettype none

module fcsi_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic [fcsi_pkg::CMD_W-1:0]     i_command,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [fcsi_pkg::DATA_W-1:0]    o_set_index,
    input wire logic [fcsi_pkg::DATA_W-1:0]    o_encrypted_line
);

    // A stalled result stays valid and keeps its encrypted line until the transfer completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_encrypted_line)))
        else $error("result changed or dropped while stalled");

    // The set index is always a masked copy of the encrypted line.
    a_index_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_set_index & ~o_encrypted_line) == '0))
        else $error("set index has bits outside the encrypted line");

    // A compute transfer occupies the round sequencer.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command == fcsi_pkg::CMD_COMPUTE))
        |=> !o_in_ready)
        else $error("input ready right after a compute transfer");

    // A table write leaves the input ready in the cycle after it.
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command != fcsi_pkg::CMD_COMPUTE))
        |=> o_in_ready)
        else $error("input not ready after a table write");

endmodule

bind feistel_cache_set_index fcsi_checker u_fcsi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_command       (i_command),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_set_index     (o_set_index),
    .o_encrypted_line(o_encrypted_line)
);

`default_nettype wire
